/* rtl/core/atou_pkg.sv */
// Package for the ASCII to unsigned integer parser.
// Types, widths and constants shared by front, queue, back and top level.
// No dependencies.
`default_nettype none

package atou_pkg;

    localparam int VALUE_BITS    = 64;
    localparam int POSITION_BITS = 16;
    localparam int RADIX_BITS    = 6;
    localparam int DIGIT_BITS    = 6;
    localparam int CHAR_BITS     = 8;
    localparam int CONSUMED_BITS = 16;
    localparam int PROD_BITS     = VALUE_BITS + RADIX_BITS;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_BITS      = 88;

    localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);
    localparam logic [RADIX_BITS-1:0] RADIX_AUTO  = RADIX_BITS'(0);
    localparam logic [RADIX_BITS-1:0] RADIX_BIN   = RADIX_BITS'(2);
    localparam logic [RADIX_BITS-1:0] RADIX_OCT   = RADIX_BITS'(8);
    localparam logic [RADIX_BITS-1:0] RADIX_DEC   = RADIX_BITS'(10);
    localparam logic [RADIX_BITS-1:0] RADIX_HEX   = RADIX_BITS'(16);
    localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(36);
    localparam logic [DIGIT_BITS-1:0] NO_DIGIT    = DIGIT_BITS'(36);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_START,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic                  first;
        logic [DIGIT_BITS-1:0] digit;
        logic                  space;
        logic                  plus;
        logic                  minus;
        logic                  letter_x;
        logic                  letter_b;
    } t_item;

    typedef struct packed {
        logic                     bad_base;
        logic [CONSUMED_BITS-1:0] consumed;
        logic                     overflow;
        logic                     negative;
        logic [VALUE_BITS-1:0]    value;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/atou_front.sv */
// Input side of the parser: takes character words and classifies them.
// Depends on atou_pkg.
`default_nettype none

module atou_front (
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [atou_pkg::CHAR_BITS-1:0]    s_axis_tdata,
    input  wire logic                              s_axis_tuser,
    input  wire logic                              i_full,
    output logic                                   o_push,
    output atou_pkg::t_item                        o_item
);
    import atou_pkg::*;

    logic [CHAR_BITS-1:0] w_ch;
    logic [CHAR_BITS-1:0] w_low;

    assign w_ch  = s_axis_tdata;
    assign w_low = w_ch | CHAR_BITS'(8'h20);

    assign s_axis_tready = !i_full;
    assign o_push        = s_axis_tvalid && !i_full;

    always_comb begin
        o_item.first    = s_axis_tuser;
        o_item.space    = (w_ch == 8'h20) || (w_ch >= 8'h09 && w_ch <= 8'h0d);
        o_item.plus     = (w_ch == 8'h2b);
        o_item.minus    = (w_ch == 8'h2d);
        o_item.letter_x = (w_low == 8'h78);
        o_item.letter_b = (w_low == 8'h62);
        priority if (w_ch >= 8'h30 && w_ch <= 8'h39) begin
            o_item.digit = DIGIT_BITS'(w_ch - 8'h30);
        end else if (w_ch >= 8'h41 && w_ch <= 8'h5a) begin
            o_item.digit = DIGIT_BITS'(w_ch - 8'h37);
        end else if (w_ch >= 8'h61 && w_ch <= 8'h7a) begin
            o_item.digit = DIGIT_BITS'(w_ch - 8'h57);
        end else begin
            o_item.digit = NO_DIGIT;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/atou_queue.sv */
// Short queue of classified character words between front and back.
// Depends on atou_pkg.
`default_nettype none

module atou_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire atou_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output atou_pkg::t_item o_item,
    input  wire logic      i_pop
);
    import atou_pkg::*;

    t_item                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] n_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QPTR_BITS-1:0] n_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QCNT_BITS-1:0] n_count;

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/atou_back.sv */
// Parse sequencer: prefix handling, digit accumulation, result register.
// Holds the radix register. Depends on atou_pkg.
`default_nettype none

module atou_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    input  wire logic [atou_pkg::RADIX_BITS-1:0]   i_cfg_data,
    input  wire logic                              i_valid,
    input  wire atou_pkg::t_item                   i_item,
    output logic                                   o_pop,
    output logic                                   o_res_valid,
    input  wire logic                              i_res_ready,
    output atou_pkg::t_result                      o_res
);
    import atou_pkg::*;

    logic [RADIX_BITS-1:0]    r_radix;
    t_phase                   r_phase;
    t_phase                   n_phase;
    logic [RADIX_BITS-1:0]    r_base;
    logic [RADIX_BITS-1:0]    n_base;
    logic [VALUE_BITS-1:0]    r_acc;
    logic [VALUE_BITS-1:0]    n_acc;
    logic                     r_sign;
    logic                     n_sign;
    logic                     r_ovf;
    logic                     n_ovf;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] n_pos;
    logic [POSITION_BITS-1:0] r_cend;
    logic [POSITION_BITS-1:0] n_cend;
    logic                     r_out_valid;
    t_result                  r_out;
    t_result                  w_res;
    logic                     w_live;
    logic                     w_start;
    logic                     w_take;
    logic                     w_emit;
    logic                     w_bad;
    logic [PROD_BITS-1:0]     w_prod;

    assign o_pop       = i_valid && (!r_out_valid || i_res_ready);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        n_phase = r_phase;
        n_base  = r_base;
        n_acc   = r_acc;
        n_sign  = r_sign;
        n_ovf   = r_ovf;
        n_pos   = r_pos;
        n_cend  = r_cend;
        w_live  = 1'b0;
        w_start = 1'b0;
        w_take  = 1'b0;
        w_emit  = 1'b0;
        w_bad   = 1'b0;
        w_prod  = '0;
        if (o_pop) begin
            w_live = 1'b1;
            if (i_item.first) begin
                n_base  = r_radix;
                n_acc   = '0;
                n_sign  = 1'b0;
                n_ovf   = 1'b0;
                n_pos   = '0;
                n_cend  = '0;
                n_phase = PH_LEAD;
                if (r_radix == RADIX_BITS'(1) || r_radix > RADIX_MAX) begin
                    w_emit  = 1'b1;
                    w_bad   = 1'b1;
                    w_live  = 1'b0;
                    n_phase = PH_DONE;
                end
            end else if (r_phase == PH_IDLE || r_phase == PH_DONE) begin
                w_live = 1'b0;
            end
        end
        if (w_live) begin
            n_pos = (n_pos == POS_MAX) ? n_pos : n_pos + 1'b1;
            unique case (n_phase)
                PH_LEAD: begin
                    priority if (i_item.space) begin
                        n_phase = PH_LEAD;
                    end else if (i_item.plus) begin
                        n_phase = PH_START;
                    end else if (i_item.minus) begin
                        n_sign  = 1'b1;
                        n_phase = PH_START;
                    end else begin
                        w_start = 1'b1;
                    end
                end
                PH_START: begin
                    w_start = 1'b1;
                end
                PH_ZERO: begin
                    priority if ((n_base == RADIX_AUTO || n_base == RADIX_HEX)
                                 && i_item.letter_x) begin
                        n_base  = RADIX_HEX;
                        n_phase = PH_PREFIX;
                    end else if ((n_base == RADIX_AUTO || n_base == RADIX_BIN)
                                 && i_item.letter_b) begin
                        n_base  = RADIX_BIN;
                        n_phase = PH_PREFIX;
                    end else begin
                        if (n_base == RADIX_AUTO) begin
                            n_base = RADIX_OCT;
                        end
                        w_take = 1'b1;
                    end
                end
                default: begin
                    w_take = 1'b1;
                end
            endcase
            if (w_start) begin
                if (i_item.digit == '0 && (n_base == RADIX_AUTO || n_base == RADIX_HEX
                                           || n_base == RADIX_BIN)) begin
                    n_cend  = n_pos;
                    n_phase = PH_ZERO;
                end else begin
                    if (n_base == RADIX_AUTO) begin
                        n_base = RADIX_DEC;
                    end
                    w_take = 1'b1;
                end
            end
            if (w_take) begin
                if (n_base < RADIX_BIN || RADIX_BITS'(i_item.digit) >= n_base) begin
                    w_emit  = 1'b1;
                    n_phase = PH_DONE;
                end else begin
                    w_prod = PROD_BITS'(n_acc) * PROD_BITS'(n_base)
                             + PROD_BITS'(i_item.digit);
                    if (!n_ovf) begin
                        if (w_prod[PROD_BITS-1:VALUE_BITS] != '0) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = w_prod[VALUE_BITS-1:0];
                        end
                    end
                    n_cend  = n_pos;
                    n_phase = PH_DIGITS;
                end
            end
        end
    end

    always_comb begin
        w_res.bad_base = w_bad;
        w_res.value    = w_bad ? '0 : (n_ovf ? '1 : n_acc);
        w_res.negative = !w_bad && (n_cend != '0) && n_sign;
        w_res.overflow = !w_bad && n_ovf;
        w_res.consumed = w_bad ? '0 : CONSUMED_BITS'(n_cend);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix     <= RADIX_RESET;
            r_phase     <= PH_IDLE;
            r_base      <= '0;
            r_acc       <= '0;
            r_sign      <= 1'b0;
            r_ovf       <= 1'b0;
            r_pos       <= '0;
            r_cend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_radix <= i_cfg_data;
            end
            r_phase <= n_phase;
            r_base  <= n_base;
            r_acc   <= n_acc;
            r_sign  <= n_sign;
            r_ovf   <= n_ovf;
            r_pos   <= n_pos;
            r_cend  <= n_cend;
            if (o_pop && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/ascii_to_unsigned_integer.sv */
// Streaming strtoul-style parser, top level.
// Instantiates atou_front, atou_queue and atou_back; depends on atou_pkg.
//
// Usage:
//   s_axis carries one character word per transfer: tdata[7:0] is the
//   character, tuser[0] marks the first character of a string. Code 0
//   ends a string; any character that cannot extend the number ends it.
//   m_axis carries one result word per parsed string, emitted on the
//   character that ends the number (or on the first character when the
//   radix is invalid). Characters after the result are dropped until the
//   next first-marked character.
//   The cfg channel writes the 6-bit radix; it is always ready and must
//   only be written while no string is in flight.
// Timing:
//   A result is registered in the back sequencer when the ending character
//   leaves the queue. Throughput is one character per cycle while m_axis
//   is not stalling; the sequencer's digit multiply-accumulate is combinational.
//   A four-word queue decouples input from the sequencer; when m_axis
//   stalls with a result held, the sequencer halts and s_axis_tready
//   drops once the queue fills.
// Reset: radix returns to 10, queue and result register empty.
`default_nettype none

module ascii_to_unsigned_integer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [atou_pkg::RADIX_BITS-1:0]   i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [7:0] ch
    input  wire logic [atou_pkg::CHAR_BITS-1:0]    s_axis_tdata,
    // [0] first
    input  wire logic                              s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [63:0] value, [64] negative, [65] overflow, [81:66] consumed,
    // [82] bad_base, [87:83] zero
    output logic [atou_pkg::OUT_BITS-1:0]          m_axis_tdata
);
    import atou_pkg::*;

    t_item   w_push_item;
    t_item   w_head_item;
    t_result w_res;
    logic    w_push;
    logic    w_full;
    logic    w_head_valid;
    logic    w_pop;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = OUT_BITS'(w_res);

    atou_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_item        (w_push_item)
    );

    atou_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .o_item  (w_head_item),
        .i_pop   (w_pop)
    );

    atou_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (w_head_valid),
        .i_item      (w_head_item),
        .o_pop       (w_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    a_bad_base_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.bad_base |->
            w_res.value == '0 && w_res.consumed == '0 && !w_res.negative
            && !w_res.overflow)
        else $error("bad base result carries data");

    a_overflow_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.overflow |-> w_res.value == '1)
        else $error("overflow result not saturated");

    a_negative_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.negative |-> w_res.consumed != '0)
        else $error("negative result without digits");

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid && (!m_axis_tvalid || m_axis_tready))
        else $error("sequencer took a word it could not hold");

endmodule

`default_nettype wire
